@@ rtl/ldb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldb_pkg: shared types and constants of the lockout debouncer
// Field widths, register reset values, register indexes, action codes and lane structs.
// ----------------------------------------------------------------------------
package ldb_pkg;

	// field widths
	localparam int NOW_W     = 32;
	localparam int LOCKOUT_W = 16;
	localparam int HOLD_W    = 32;
	localparam int BTN_W     = 3;
	localparam int MAP_W     = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 32;

	// register reset values
	localparam logic [LOCKOUT_W-1:0] LOCKOUT_MS_RST  = 16'd3;
	localparam logic [HOLD_W-1:0]    HOLD_MS_RST     = 32'd5000;
	localparam logic [BTN_W-1:0]     HOLD_BUTTON_RST = 3'd6;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOCKOUT_MS  = 2'd0,
		CFG_HOLD_MS     = 2'd1,
		CFG_HOLD_BUTTON = 2'd2
	} cfg_idx_t;

	// action codes
	localparam logic ACT_CHANGE = 1'b0;
	localparam logic ACT_POLL   = 1'b1;

	// broadcast from the top level to every lane
	typedef struct packed {
		logic                 strobe;
		logic                 level;
		logic [NOW_W-1:0]     now_ms;
		logic [LOCKOUT_W-1:0] lockout_ms;
	} lane_cmd_t;

	// status returned by one lane
	typedef struct packed {
		logic take;
		logic level_next;
	} lane_stat_t;

endpackage

@@ rtl/ldb_cmd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldb_cmd_if: event channel
// Valid/ready channel that carries one change event or hold poll.
// ----------------------------------------------------------------------------
interface ldb_cmd_if;
	logic                       valid;
	logic                       ready;
	logic                       action;
	logic [ldb_pkg::BTN_W-1:0]  button_index;
	logic                       raw_pressed;
	logic [ldb_pkg::NOW_W-1:0]  now_ms;

	modport source (output valid, action, button_index, raw_pressed, now_ms, input ready);
	modport sink   (input valid, action, button_index, raw_pressed, now_ms, output ready);
endinterface

@@ rtl/ldb_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldb_rsp_if: result channel
// Valid/ready channel that carries the stable map and the bootloader flag.
// ----------------------------------------------------------------------------
interface ldb_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [ldb_pkg::MAP_W-1:0]  pressed_map;
	logic                       enter_bootloader;

	modport source (output valid, pressed_map, enter_bootloader, input ready);
	modport sink   (input valid, pressed_map, enter_bootloader, output ready);
endinterface

@@ rtl/ldb_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldb_lane: debounce state of one button
// Holds the stable level and the lockout deadline, takes a new level once
// the deadline has passed and the level differs.
// ----------------------------------------------------------------------------
module ldb_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sel,
	input  ldb_pkg::lane_cmd_t  cmd,
	output ldb_pkg::lane_stat_t stat
);

	logic                      stable_q;
	logic [ldb_pkg::NOW_W-1:0] deadline_q;
	logic                      take;

	// accept a change past the deadline that really changes the level
	assign take = cmd.strobe && sel && (cmd.now_ms >= deadline_q) && (cmd.level != stable_q);

	assign stat.take       = take;
	assign stat.level_next = take ? cmd.level : stable_q;

	// stable level and deadline, wraps modulo 2^32
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q   <= 1'b0;
			deadline_q <= '0;
		end else if (take) begin
			stable_q   <= cmd.level;
			deadline_q <= cmd.now_ms
				+ {{(ldb_pkg::NOW_W - ldb_pkg::LOCKOUT_W){1'b0}}, cmd.lockout_ms};
		end
	end

endmodule

@@ rtl/lockout_debouncer_with_long_press.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lockout_debouncer_with_long_press: per-button debouncer with hold detect
// Lockout debouncer for BUTTON_COUNT buttons plus long-press timing on one
// configurable button; every transaction returns the stable pressed map.
//
//   channel  dir  payload                                   accepted when
//   cmd      in   action, button_index, raw_pressed, now_ms valid && ready
//   rsp      out  pressed_map, enter_bootloader             valid && ready
//   cfg      in   cfg_index, cfg_data                       cfg_write
//
// One transaction per cycle while rsp is not stalled; the accepting edge loads
// the input register, and the result register is then loaded from it through
// the compare/add logic once it is free or drains.
// cmd.ready drops only while both the input and result registers are full
// and rsp is stalled. Reset clears all button state and loads register
// defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lockout_debouncer_with_long_press #(
	parameter int BUTTON_COUNT = 7
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [ldb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ldb_pkg::CFG_W-1:0]         cfg_data,
	ldb_cmd_if.sink                           cmd,
	ldb_rsp_if.source                         rsp
);

	// configuration registers
	logic [ldb_pkg::LOCKOUT_W-1:0] lockout_q;
	logic [ldb_pkg::HOLD_W-1:0]    hold_ms_q;
	logic [ldb_pkg::BTN_W-1:0]     hold_button_q;

	// input register
	logic                       valid_s1;
	logic                       action_s1;
	logic [ldb_pkg::BTN_W-1:0]  button_s1;
	logic                       raw_s1;
	logic [ldb_pkg::NOW_W-1:0]  now_s1;

	// hold tracking
	logic [ldb_pkg::NOW_W-1:0]  hold_start_q;
	logic                       hold_active_q;

	// result register
	logic                       rsp_valid_q;
	logic [ldb_pkg::MAP_W-1:0]  map_q;
	logic                       flag_q;

	logic                       advance;
	ldb_pkg::lane_cmd_t         lane_cmd;
	ldb_pkg::lane_stat_t        lane_stat [BUTTON_COUNT];
	logic [BUTTON_COUNT-1:0]    lane_sel;
	logic [BUTTON_COUNT-1:0]    hold_hit;
	logic                       hold_take;
	logic                       poll_flag;
	logic [ldb_pkg::MAP_W-1:0]  map_next;
	logic [ldb_pkg::NOW_W-1:0]  elapsed;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lockout_q     <= ldb_pkg::LOCKOUT_MS_RST;
			hold_ms_q     <= ldb_pkg::HOLD_MS_RST;
			hold_button_q <= ldb_pkg::HOLD_BUTTON_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				ldb_pkg::CFG_LOCKOUT_MS:  lockout_q     <= cfg_data[ldb_pkg::LOCKOUT_W-1:0];
				ldb_pkg::CFG_HOLD_MS:     hold_ms_q     <= cfg_data[ldb_pkg::HOLD_W-1:0];
				ldb_pkg::CFG_HOLD_BUTTON: hold_button_q <= cfg_data[ldb_pkg::BTN_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake: stage 1 moves on when the result register is free or drains
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign cmd.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			action_s1 <= cmd.action;
			button_s1 <= cmd.button_index;
			raw_s1    <= cmd.raw_pressed;
			now_s1    <= cmd.now_ms;
		end
	end

	// broadcast to the lanes
	assign lane_cmd.strobe     = advance && (action_s1 == ldb_pkg::ACT_CHANGE);
	assign lane_cmd.level      = raw_s1;
	assign lane_cmd.now_ms     = now_s1;
	assign lane_cmd.lockout_ms = lockout_q;

	// one lane per button; indexes beyond the count select nothing
	for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_lane
		assign lane_sel[i] = (32'(button_s1) == i);
		assign hold_hit[i] = (32'(hold_button_q) == i) && lane_stat[i].take;

		ldb_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.sel    (lane_sel[i]),
			.cmd    (lane_cmd),
			.stat   (lane_stat[i])
		);
	end

	assign hold_take = |hold_hit;

	// pack the post-update levels, missing buttons read as released
	for (genvar k = 0; k < ldb_pkg::MAP_W; k++) begin : g_map
		if (k < BUTTON_COUNT) begin : g_bit
			assign map_next[k] = lane_stat[k].level_next;
		end else begin : g_zero
			assign map_next[k] = 1'b0;
		end
	end

	// hold start time, zero means none
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_start_q  <= '0;
			hold_active_q <= 1'b0;
		end else if (hold_take) begin
			if (raw_s1) begin
				if (hold_start_q == '0) begin
					hold_start_q <= (now_s1 == '0) ? ldb_pkg::NOW_W'(1) : now_s1;
				end
				hold_active_q <= 1'b1;
			end else begin
				hold_start_q  <= '0;
				hold_active_q <= 1'b0;
			end
		end
	end

	// modular elapsed time against the hold threshold
	assign elapsed   = now_s1 - hold_start_q;
	assign poll_flag = (action_s1 == ldb_pkg::ACT_POLL) && hold_active_q
		&& (hold_start_q != '0) && (elapsed >= hold_ms_q);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			map_q  <= map_next;
			flag_q <= poll_flag;
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.pressed_map      = map_q;
	assign rsp.enter_bootloader = flag_q;

endmodule

@@ rtl/ldb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldb_checker: port-level checks of the lockout debouncer
// Watches the channels of the top level over time; bound to every instance.
// ----------------------------------------------------------------------------
module ldb_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      cmd_valid,
	input logic                      cmd_ready,
	input logic                      rsp_valid,
	input logic                      rsp_ready,
	input logic [ldb_pkg::MAP_W-1:0] pressed_map,
	input logic                      enter_bootloader
);

	// a stalled result keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(pressed_map)
			&& $stable(enter_bootloader))
		else $error("result changed while stalled");

	// a new result follows an accepted transaction through the input and result registers
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(cmd_valid && cmd_ready, 2))
		else $error("result without an accepted transaction");

	// input back-pressure only while a result is stalled
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready |-> rsp_valid && !rsp_ready)
		else $error("input stalled with a free result register");

endmodule

bind lockout_debouncer_with_long_press ldb_checker u_ldb_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.cmd_valid        (cmd.valid),
	.cmd_ready        (cmd.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.pressed_map      (rsp.pressed_map),
	.enter_bootloader (rsp.enter_bootloader)
);
